// ===== hdl/aff_pkg.sv =====
// aff_pkg: shared types and constants for the arena first-fit allocator
// no dependencies
package aff_pkg;

    localparam int OFF_W = 17;
    localparam logic [OFF_W-1:0] OFF_NONE = 17'h1FFFF;
    localparam logic [OFF_W-1:0] HDR_BYTES = 17'd12;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_RSVD  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD      = 2'd1,
        ST_NO_SPACE = 2'd2,
        ST_NO_ARENA = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_EV,
        S_AW1,
        S_AW2,
        S_AW3,
        S_FRD,
        S_FEV,
        S_FW2
    } t_state;

    typedef struct packed {
        logic [OFF_W-1:0] prev;
        logic [OFF_W-1:0] next;
        logic [OFF_W-1:0] size;
    } t_hdr;

    typedef struct packed {
        logic prev;
        logic next;
        logic size;
    } t_hdr_we;

endpackage

// ===== hdl/aff_req_if.sv =====
// aff_req_if: request channel (valid/ready plus command payload)
// depends on aff_pkg
interface aff_req_if;
    import aff_pkg::*;
    logic        valid;
    logic        ready;
    t_cmd        cmd;
    logic [16:0] req_len;
    logic [15:0] data_offset;
    modport source (output valid, cmd, req_len, data_offset, input ready);
    modport sink (input valid, cmd, req_len, data_offset, output ready);
endinterface

// ===== hdl/aff_rsp_if.sv =====
// aff_rsp_if: response channel (valid/ready plus result payload)
// depends on aff_pkg
interface aff_rsp_if;
    import aff_pkg::*;
    logic        valid;
    logic        ready;
    t_status     status;
    logic [15:0] result_offset;
    logic [16:0] block_len;
    modport source (output valid, status, result_offset, block_len, input ready);
    modport sink (input valid, status, result_offset, block_len, output ready);
endinterface

// ===== hdl/aff_hdr_mem.sv =====
// aff_hdr_mem: header store, one entry per even offset, per-field write enables
// depends on aff_pkg
module aff_hdr_mem #(
    parameter int DEPTH = 32768,
    parameter int AW = 15
) (
    input  logic            i_clk,
    input  logic [AW-1:0]   i_addr,
    input  aff_pkg::t_hdr_we i_we,
    input  aff_pkg::t_hdr   i_wdata,
    output aff_pkg::t_hdr   o_rdata
);
    import aff_pkg::*;

    logic [OFF_W-1:0] r_prev [DEPTH];
    logic [OFF_W-1:0] r_next [DEPTH];
    logic [OFF_W-1:0] r_size [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we.prev) begin
            r_prev[i_addr] <= i_wdata.prev;
        end
        if (i_we.next) begin
            r_next[i_addr] <= i_wdata.next;
        end
        if (i_we.size) begin
            r_size[i_addr] <= i_wdata.size;
        end
        o_rdata.prev <= r_prev[i_addr];
        o_rdata.next <= r_next[i_addr];
        o_rdata.size <= r_size[i_addr];
    end

endmodule

// ===== hdl/aff_fit_unit.sv =====
// aff_fit_unit: gap test, does a block of len12 bytes fit after a node
// depends on aff_pkg
module aff_fit_unit (
    input  logic [aff_pkg::OFF_W-1:0] i_node,
    input  logic [aff_pkg::OFF_W-1:0] i_next,
    input  logic [aff_pkg::OFF_W-1:0] i_size,
    input  logic [17:0]               i_len12,
    input  logic [24:0]               i_alen,
    output logic                      o_fit,
    output logic [aff_pkg::OFF_W-1:0] o_blk
);
    import aff_pkg::*;

    logic [24:0] w_need;
    logic [24:0] w_end;

    assign w_need = 25'(i_node) + 25'(i_size) + 25'(i_len12);
    assign w_end  = (i_next == OFF_NONE) ? i_alen : 25'(i_next);
    assign o_fit  = (w_need <= w_end);
    assign o_blk  = i_node + i_size;

endmodule

// ===== hdl/arena_first_fit_allocator.sv =====
// arena_first_fit_allocator: top level, sequencer walking the block list
// depends on aff_pkg, aff_req_if, aff_rsp_if, aff_hdr_mem, aff_fit_unit
//
// usage:
// - i_req carries cmd (allocate, free, query length), req_len and data_offset;
//   o_rsp returns one result (status, result_offset, block_len) per request
// - i_cfg_we/i_cfg_wdata write arena_bytes; nonzero rebuilds the empty head at
//   offset 0 and sets the cursor there; write only while idle
// - allocate walks the list from the cursor backward, then forward; each node
//   visited takes a header read and a fit test, linking costs 1 to 3 writes
// - free reads the header, then does 1 or 2 unlink writes; query only reads it
// - throughput is one request at a time; i_req.ready is low while a request is
//   in work or a result waits in the output register
// - a stalled receiver holds the result; no new request is taken until the
//   result transfer completes
// - synchronous reset clears control state; header entries are undefined until
//   written, so no clearing pass is needed
module arena_first_fit_allocator #(
    parameter int ARENA_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,
    aff_req_if.sink     i_req,
    aff_rsp_if.source   o_rsp
);
    import aff_pkg::*;

    localparam int DEPTH = ARENA_BYTES / 2;
    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0] STEP_MAX = (AW+1)'(DEPTH);

    t_state           r_state, n_state;
    logic [OFF_W-1:0] r_node, n_node;
    logic [OFF_W-1:0] r_blk, n_blk;
    logic [OFF_W-1:0] r_nx, n_nx;
    logic [OFF_W-1:0] r_before, n_before;
    logic [OFF_W-1:0] r_cursor, n_cursor;
    logic [AW:0]      r_steps, n_steps;
    logic             r_fwd, n_fwd;
    logic             r_first, n_first;
    logic             r_query, n_query;
    logic [17:0]      r_len12, n_len12;
    logic [16:0]      r_arena;
    logic             r_ovalid, n_ovalid;
    t_status          r_status, n_status;
    logic [15:0]      r_roff, n_roff;
    logic [16:0]      r_blen, n_blen;

    logic [AW-1:0]    w_addr;
    t_hdr_we          w_we;
    t_hdr             w_wdata;
    t_hdr             w_rdata;
    logic [24:0]      w_alen;
    logic             w_fit;
    logic [OFF_W-1:0] w_fblk;
    logic [17:0]      w_lenr;
    logic [AW:0]      w_step1;

    function automatic logic [AW-1:0] f_idx(input logic [OFF_W-1:0] off);
        return AW'(off >> 1);
    endfunction

    assign w_alen = (25'(r_arena) > 25'(ARENA_BYTES)) ? 25'(ARENA_BYTES) : 25'(r_arena);
    assign w_lenr = 18'(i_req.req_len) + 18'(i_req.req_len[0]);
    assign w_step1 = r_steps + 1'b1;

    aff_hdr_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_addr  (w_addr),
        .i_we    (w_we),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    aff_fit_unit u_fit (
        .i_node  (r_node),
        .i_next  (w_rdata.next),
        .i_size  (w_rdata.size),
        .i_len12 (r_len12),
        .i_alen  (w_alen),
        .o_fit   (w_fit),
        .o_blk   (w_fblk)
    );

    assign i_req.ready     = (r_state == S_IDLE) && !r_ovalid && !i_cfg_we;
    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.status    = r_status;
    assign o_rsp.result_offset = r_roff;
    assign o_rsp.block_len = r_blen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cursor <= OFF_NONE;
            r_arena  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_arena <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_node   <= n_node;
        r_blk    <= n_blk;
        r_nx     <= n_nx;
        r_before <= n_before;
        r_steps  <= n_steps;
        r_fwd    <= n_fwd;
        r_first  <= n_first;
        r_query  <= n_query;
        r_len12  <= n_len12;
        r_status <= n_status;
        r_roff   <= n_roff;
        r_blen   <= n_blen;
    end

    always_comb begin
        n_state  = r_state;
        n_node   = r_node;
        n_blk    = r_blk;
        n_nx     = r_nx;
        n_before = r_before;
        n_cursor = r_cursor;
        n_steps  = r_steps;
        n_fwd    = r_fwd;
        n_first  = r_first;
        n_query  = r_query;
        n_len12  = r_len12;
        n_ovalid = r_ovalid;
        n_status = r_status;
        n_roff   = r_roff;
        n_blen   = r_blen;
        w_addr   = f_idx(r_node);
        w_we     = '0;
        w_wdata  = '{prev: OFF_NONE, next: OFF_NONE, size: '0};

        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cfg_we) begin
                    if (i_cfg_wdata != '0) begin
                        w_addr   = f_idx('0);
                        w_we     = '{prev: 1'b1, next: 1'b1, size: 1'b1};
                        n_cursor = '0;
                    end else begin
                        n_cursor = OFF_NONE;
                    end
                end else if (i_req.valid && i_req.ready) begin
                    n_len12  = w_lenr + 18'(HDR_BYTES);
                    n_roff   = '0;
                    n_blen   = '0;
                    n_status = ST_BAD;
                    n_ovalid = 1'b1;
                    n_query  = (i_req.cmd == CMD_QUERY);
                    n_node   = 17'(i_req.data_offset) - HDR_BYTES;
                    case (i_req.cmd)
                        CMD_ALLOC: begin
                            if (i_req.req_len == '0) begin
                                n_status = ST_BAD;
                            end else if (r_arena == '0) begin
                                n_status = ST_NO_ARENA;
                            end else if (r_cursor == OFF_NONE) begin
                                n_status = ST_NO_SPACE;
                            end else begin
                                n_ovalid = 1'b0;
                                n_node   = r_cursor;
                                n_steps  = '0;
                                n_fwd    = 1'b0;
                                n_first  = 1'b0;
                                n_state  = S_RD;
                            end
                        end
                        CMD_FREE, CMD_QUERY: begin
                            if (r_arena == '0) begin
                                n_status = ST_NO_ARENA;
                            end else if (i_req.data_offset < 16'(HDR_BYTES)
                                         || i_req.data_offset[0]) begin
                                n_status = ST_BAD;
                            end else begin
                                n_ovalid = 1'b0;
                                n_state  = S_FRD;
                            end
                        end
                        default: begin
                            n_status = ST_BAD;
                        end
                    endcase
                end
            end
            S_RD: begin
                w_addr  = f_idx(r_node);
                n_state = S_EV;
            end
            S_EV: begin
                if (!r_first && w_fit) begin
                    n_blk    = w_fblk;
                    n_nx     = w_rdata.next;
                    n_before = (w_rdata.size == '0) ? OFF_NONE : r_node;
                    n_state  = S_AW1;
                end else if (!r_fwd) begin
                    n_steps = w_step1;
                    if (w_rdata.prev != OFF_NONE && w_step1 != STEP_MAX) begin
                        n_node  = w_rdata.prev;
                        n_state = S_RD;
                    end else begin
                        n_node  = r_cursor;
                        n_steps = '0;
                        n_fwd   = 1'b1;
                        n_first = 1'b1;
                        n_state = S_RD;
                    end
                end else begin
                    if (w_rdata.next == OFF_NONE || r_steps == STEP_MAX) begin
                        n_status = ST_NO_SPACE;
                        n_ovalid = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_node  = w_rdata.next;
                        n_steps = w_step1;
                        n_first = 1'b0;
                        n_state = S_RD;
                    end
                end
            end
            S_AW1: begin
                w_addr  = f_idx(r_blk);
                w_we    = '{prev: 1'b1, next: 1'b1, size: 1'b1};
                w_wdata = '{prev: r_before, next: r_nx, size: r_len12[OFF_W-1:0]};
                if (r_before != OFF_NONE) begin
                    n_state = S_AW2;
                end else if (r_nx != OFF_NONE) begin
                    n_state = S_AW3;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_AW2: begin
                w_addr       = f_idx(r_node);
                w_we.next    = 1'b1;
                w_wdata.next = r_blk;
                n_state      = (r_nx != OFF_NONE) ? S_AW3 : S_IDLE;
            end
            S_AW3: begin
                w_addr       = f_idx(r_nx);
                w_we.prev    = 1'b1;
                w_wdata.prev = r_blk;
                n_state      = S_IDLE;
            end
            S_FRD: begin
                w_addr  = f_idx(r_node);
                n_state = S_FEV;
            end
            S_FEV: begin
                n_status = ST_OK;
                if (r_query) begin
                    n_blen   = w_rdata.size - HDR_BYTES;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_nx = w_rdata.next;
                    if (w_rdata.prev != OFF_NONE) begin
                        w_addr       = f_idx(w_rdata.prev);
                        w_we.next    = 1'b1;
                        w_wdata.next = w_rdata.next;
                        n_before     = w_rdata.prev;
                    end else begin
                        w_addr       = f_idx('0);
                        w_we         = '{prev: 1'b1, next: 1'b1, size: 1'b1};
                        w_wdata.next = w_rdata.next;
                        n_before     = '0;
                    end
                    n_cursor = n_before;
                    if (w_rdata.next != OFF_NONE) begin
                        n_state = S_FW2;
                    end else begin
                        n_ovalid = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end
            S_FW2: begin
                w_addr       = f_idx(r_nx);
                w_we.prev    = 1'b1;
                w_wdata.prev = r_before;
                n_ovalid     = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if ((r_state == S_AW1 && n_state == S_IDLE) || r_state == S_AW2 && n_state == S_IDLE
            || r_state == S_AW3) begin
            n_cursor = r_blk;
            n_status = ST_OK;
            n_roff   = 16'(r_blk + HDR_BYTES);
            n_ovalid = 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_ready_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_rsp.valid)
        else $error("request taken while a result is pending");

    a_cursor_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_arena != '0) |-> (r_cursor != OFF_NONE))
        else $error("cursor lost while arena exists");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && !i_cfg_we) |=> !i_req.ready)
        else $error("second request taken back to back");
`endif

endmodule

// ===== dv/aff_req_if.sv =====
// aff_req_if: the testbench uses the request and response channels of the block
// depends on hdl/aff_req_if.sv and hdl/aff_rsp_if.sv, which hold both interfaces

// ===== dv/arena_alloc_checker.sv =====
// arena_alloc_checker: watches request, response and arena writes, predicts every
// result from its own model of the header list and compares all fields at once
// depends on aff_pkg, aff_req_if, aff_rsp_if
module arena_alloc_checker
    import aff_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,
    aff_req_if          req,
    aff_rsp_if          rsp,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int DEPTH = 32768;
    localparam logic [16:0] ARENA_MAX = 17'h10000;

    typedef struct packed {
        t_status     status;
        logic [15:0] result_offset;
        logic [16:0] block_len;
    } t_result;

    t_hdr        hdrs [DEPTH];
    logic [16:0] roving;
    logic [16:0] arena;
    t_result     expected_q [$];

    function automatic int slot(logic [16:0] off);
        return int'(off >> 1) % DEPTH;
    endfunction

    function automatic bit try_place(logic [16:0] node, logic [17:0] len,
                                     output logic [16:0] got);
        logic [16:0] nx;
        logic [16:0] sz;
        logic [16:0] blk;
        logic [16:0] prv;
        longint      room;
        nx = hdrs[slot(node)].next;
        sz = hdrs[slot(node)].size;
        room = longint'(nx == OFF_NONE ? arena : nx) - longint'(node) - longint'(sz) - 12;
        got = '0;
        if (longint'(len) > room) return 0;
        blk = node + sz;
        prv = (sz == 0) ? OFF_NONE : node;
        hdrs[slot(blk)].prev = prv;
        hdrs[slot(blk)].next = nx;
        hdrs[slot(blk)].size = 17'(len + 18'(HDR_BYTES));
        if (prv != OFF_NONE) hdrs[slot(prv)].next = blk;
        if (nx != OFF_NONE) hdrs[slot(nx)].prev = blk;
        roving = blk;
        got = blk;
        return 1;
    endfunction

    function automatic t_status allocate(logic [16:0] len_in, output logic [16:0] got);
        logic [17:0] len;
        logic [16:0] node;
        int          steps;
        got = '0;
        if (len_in == 0) return ST_BAD;
        len = 18'(len_in) + 18'(len_in[0]);
        if (arena == 0) return ST_NO_ARENA;
        node = roving;
        for (steps = 0; node != OFF_NONE && steps < DEPTH; steps++) begin
            if (try_place(node, len, got)) return ST_OK;
            node = hdrs[slot(node)].prev;
        end
        node = roving;
        if (node == OFF_NONE) return ST_NO_SPACE;
        for (steps = 0; steps < DEPTH; steps++) begin
            node = hdrs[slot(node)].next;
            if (node == OFF_NONE) break;
            if (try_place(node, len, got)) return ST_OK;
        end
        return ST_NO_SPACE;
    endfunction

    function automatic void release_block(logic [16:0] blk);
        logic [16:0] prv;
        logic [16:0] nx;
        prv = hdrs[slot(blk)].prev;
        nx = hdrs[slot(blk)].next;
        if (prv != OFF_NONE) begin
            hdrs[slot(prv)].next = nx;
        end else begin
            prv = 0;
            hdrs[0] = '{prev: OFF_NONE, next: nx, size: 17'd0};
        end
        if (nx != OFF_NONE) hdrs[slot(nx)].prev = prv;
        roving = prv;
    endfunction

    function automatic t_result predict(t_cmd cmd, logic [16:0] len, logic [15:0] off);
        t_result     r;
        logic [16:0] got;
        logic [16:0] blk;
        r = '{status: ST_BAD, result_offset: 16'd0, block_len: 17'd0};
        blk = {1'b0, off} - HDR_BYTES;
        if (cmd == CMD_ALLOC) begin
            r.status = allocate(len, got);
            if (r.status == ST_OK) r.result_offset = 16'(got + HDR_BYTES);
        end else if (cmd == CMD_FREE || cmd == CMD_QUERY) begin
            if (arena == 0) begin
                r.status = ST_NO_ARENA;
            end else if (off < 12 || off[0]) begin
                r.status = ST_BAD;
            end else begin
                r.status = ST_OK;
                if (cmd == CMD_FREE) release_block(blk);
                else r.block_len = hdrs[slot(blk)].size - HDR_BYTES;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got_r;
        t_result exp_r;
        if (!i_rst_n) begin
            roving = OFF_NONE;
            arena = '0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                arena = (i_cfg_wdata > ARENA_MAX) ? ARENA_MAX : i_cfg_wdata;
                if (i_cfg_wdata == 0) begin
                    roving = OFF_NONE;
                end else begin
                    hdrs[0] = '{prev: OFF_NONE, next: OFF_NONE, size: 17'd0};
                    roving = 0;
                end
            end
            if (rsp.valid && rsp.ready) begin
                got_r = '{status: rsp.status, result_offset: rsp.result_offset,
                          block_len: rsp.block_len};
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result transfer: %p", got_r);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got_r !== exp_r) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p actual %p", exp_r, got_r);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (req.valid && req.ready)
                expected_q.push_back(predict(req.cmd, req.req_len, req.data_offset));
        end
        o_pending <= expected_q.size();
    end
endmodule

// ===== dv/arena_first_fit_allocator_test.sv =====
// arena_first_fit_allocator_test: drives allocate, free and query traffic over
// several arena sizes, idle and stall phases; verdict from arena_alloc_checker
// depends on aff_pkg, aff_req_if, aff_rsp_if, arena_alloc_checker and the block
module arena_first_fit_allocator_test;
    import aff_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_we = 0;
    logic [16:0] cfg_wdata = 0;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;
    logic [15:0] live_q [$];

    aff_req_if req ();
    aff_rsp_if rsp ();

    arena_first_fit_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_req(req), .o_rsp(rsp)
    );

    arena_alloc_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .req(req), .rsp(rsp), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    initial begin
        #4000000;
        $display("[arena_first_fit_allocator] ERROR");
        $finish;
    end

    initial begin
        req.valid = 0;
        req.cmd = CMD_ALLOC;
        req.req_len = 0;
        req.data_offset = 0;
        rsp.ready = 0;
    end

    // receiver stall process, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp.ready <= 0;
        end else begin
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // valid stays high after a transfer until the next idle cycle or drain
    task automatic send(t_cmd cmd, logic [16:0] len, logic [15:0] off);
        while ($urandom_range(99) < send_idle_pct) begin
            req.valid <= 0;
            @(posedge i_clk);
        end
        req.valid <= 1;
        req.cmd <= cmd;
        req.req_len <= len;
        req.data_offset <= off;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        req.valid <= 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_arena(logic [16:0] val);
        drain();
        cfg_we <= 1;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we <= 0;
        live_q.delete();
    endtask

    // result offsets are learned by watching transfers
    always @(posedge i_clk) begin
        if (rsp.valid && rsp.ready && rsp.status == ST_OK && rsp.result_offset != 0)
            live_q.push_back(rsp.result_offset);
    end

    task automatic random_items(int n, int max_len);
        int          k;
        int          pick;
        int          idx;
        logic [16:0] len;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                len = (pick < 3) ? 17'($urandom_range(65536)) : 17'($urandom_range(max_len));
                send(CMD_ALLOC, len, 16'($urandom));
            end else if (pick < 92) begin
                drain();
                if (live_q.size() == 0) begin
                    send(CMD_QUERY, 17'($urandom), 16'($urandom_range(11)));
                end else begin
                    idx = $urandom_range(live_q.size() - 1);
                    if (pick < 75) begin
                        send(CMD_FREE, 17'($urandom), live_q[idx]);
                        live_q.delete(idx);
                    end else begin
                        send(CMD_QUERY, 17'($urandom), live_q[idx]);
                    end
                end
            end else if (pick < 96) begin
                send(pick[0] ? CMD_FREE : CMD_QUERY, 17'($urandom),
                     16'($urandom_range(5) * 2 + pick[1]));
            end else begin
                send(CMD_RSVD, 17'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: arena not created, zero length, bad offsets, reserved command
        send(CMD_ALLOC, 17'd0, 16'd0);
        send(CMD_ALLOC, 17'd5, 16'd0);
        send(CMD_FREE, 17'd0, 16'd12);
        send(CMD_QUERY, 17'd0, 16'hFFFF);
        send(CMD_RSVD, 17'h1FFFF, 16'hFFFF);
        set_arena(17'h1FFFF);
        send(CMD_QUERY, 17'd0, 16'd12);
        send(CMD_ALLOC, 17'd1, 16'd0);
        send(CMD_ALLOC, 17'h10000, 16'd0);
        send(CMD_ALLOC, 17'd65524, 16'd0);
        send(CMD_FREE, 17'd0, 16'd11);
        send(CMD_FREE, 17'd0, 16'd13);
        send(CMD_QUERY, 17'd0, 16'd0);
        drain();
        send(CMD_QUERY, 17'd0, live_q[0]);
        send(CMD_FREE, 17'd0, live_q[0]);
        live_q.delete();
        send(CMD_ALLOC, 17'd65522, 16'd0);
        send(CMD_ALLOC, 17'd7, 16'd0);
        drain();
        send(CMD_FREE, 17'd0, live_q[0]);
        live_q.delete();
        set_arena(17'd0);
        send(CMD_ALLOC, 17'd4, 16'd0);
        send(CMD_FREE, 17'd0, 16'd12);

        set_arena(17'd1024);
        random_items(150, 200);
        send_idle_pct = 57;
        set_arena(17'd64);
        random_items(100, 40);
        recv_stall_pct = 57;
        send_idle_pct = 0;
        set_arena(17'd4096);
        random_items(150, 400);
        hold_cycles = 300;
        random_items(20, 60);
        send_idle_pct = 24;
        recv_stall_pct = 24;
        set_arena(17'h10000);
        random_items(200, 3000);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_arena(17'd12);
        random_items(20, 4);

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[arena_first_fit_allocator] OK");
        end else begin
            $display("[arena_first_fit_allocator] ERROR");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/aff_pkg.sv
hdl/aff_req_if.sv
hdl/aff_rsp_if.sv
hdl/aff_hdr_mem.sv
hdl/aff_fit_unit.sv
hdl/arena_first_fit_allocator.sv
dv/aff_req_if.sv
dv/arena_alloc_checker.sv
dv/arena_first_fit_allocator_test.sv
